FILE: hdl/pms_pkg.sv
`timescale 1ns / 1ps

package pms_pkg;

  localparam int unsigned WIDTH_BITS = 12;
  localparam int unsigned PIXEL_MS   = 50;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [15:0] START_PAUSE_RST = 16'd800;
  localparam logic [15:0] END_PAUSE_RST   = 16'd500;

  // command codes
  localparam logic [1:0] CMD_TIME    = 2'd0;
  localparam logic [1:0] CMD_RESTART = 2'd1;
  localparam logic [1:0] CMD_STOP    = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEXT_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VIEW_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_EN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_START_PAUSE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_PAUSE   = 3'd4;

  // scroll phases
  localparam logic [1:0] PH_START     = 2'd0;
  localparam logic [1:0] PH_TO_END    = 2'd1;
  localparam logic [1:0] PH_END_PAUSE = 2'd2;
  localparam logic [1:0] PH_TO_START  = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] current_time;
    logic [15:0] extra_delay_ms;
  } in_t;

  typedef struct packed {
    logic signed [WIDTH_BITS:0] scroll_offset;
    logic                       offset_changed;
    logic                       running;
    logic [31:0]                wait_ms;
  } out_t;

  typedef struct packed {
    logic [WIDTH_BITS-1:0] text_width;
    logic [WIDTH_BITS-1:0] viewport_width;
    logic                  scroll_enable;
    logic [15:0]           start_pause_ms;
    logic [15:0]           end_pause_ms;
  } cfg_t;

  // offset is kept as its magnitude, the offset itself is never positive
  typedef struct packed {
    logic                  armed;
    logic [1:0]            phase;
    logic [WIDTH_BITS-1:0] mag;
    logic [31:0]           deadline;
  } state_t;

endpackage

FILE: hdl/pms_update.sv
`timescale 1ns / 1ps

module pms_update (
  input  pms_pkg::in_t    item_i,
  input  pms_pkg::cfg_t   cfg_i,
  input  pms_pkg::state_t state_i,
  output pms_pkg::state_t state_o,
  output pms_pkg::out_t   res_o
);

  localparam int unsigned W  = pms_pkg::WIDTH_BITS;
  localparam int unsigned N  = W + 6;
  localparam int unsigned S  = N + 6;
  localparam int unsigned MW = S - 5;
  localparam logic [MW-1:0] RECIP = MW'((2 ** S + pms_pkg::PIXEL_MS - 1) / pms_pkg::PIXEL_MS);
  localparam logic [31:0] OVR_LIMIT = 32'(pms_pkg::PIXEL_MS) << W;

  logic [31:0]     now;
  logic [31:0]     overdue;
  logic            due;
  logic            big;
  logic [N+MW-1:0] prod;
  logic [W-1:0]    quot;
  logic [W:0]      step;
  logic [31:0]     step_ms;
  logic [W-1:0]    limit;
  logic [W+1:0]    sum_up;
  logic            can_arm;
  logic [31:0]     wait_diff;
  pms_pkg::state_t st;

  assign now     = item_i.current_time;
  assign overdue = now - state_i.deadline;
  assign due     = ~overdue[31];
  // beyond this many intervals the offset always clamps
  assign big     = overdue >= OVR_LIMIT;
  assign prod    = (N + MW)'(overdue[N-1:0]) * (N + MW)'(RECIP);
  assign quot    = prod[S+W-1:S];
  assign step    = {1'b0, quot} + (W + 1)'(1);
  assign step_ms = 32'(step) * 32'(pms_pkg::PIXEL_MS);
  assign limit   = (cfg_i.text_width > cfg_i.viewport_width) ?
                   (cfg_i.text_width - cfg_i.viewport_width) : '0;
  assign sum_up  = (W + 2)'(state_i.mag) + (W + 2)'(step);
  assign can_arm = cfg_i.scroll_enable && (cfg_i.viewport_width != '0) &&
                   (cfg_i.text_width > cfg_i.viewport_width);

  always_comb begin
    st = state_i;
    unique case (item_i.command)
      pms_pkg::CMD_TIME: begin
        if (state_i.armed && due) begin
          unique case (state_i.phase)
            pms_pkg::PH_START: begin
              st.phase    = pms_pkg::PH_TO_END;
              st.deadline = now + 32'(pms_pkg::PIXEL_MS);
            end
            pms_pkg::PH_END_PAUSE: begin
              st.phase    = pms_pkg::PH_TO_START;
              st.deadline = now + 32'(pms_pkg::PIXEL_MS);
            end
            pms_pkg::PH_TO_END: begin
              if (big || (sum_up >= (W + 2)'(limit))) begin
                st.mag      = limit;
                st.phase    = pms_pkg::PH_END_PAUSE;
                st.deadline = now + 32'(cfg_i.end_pause_ms);
              end else begin
                st.mag      = sum_up[W-1:0];
                st.deadline = state_i.deadline + step_ms;
              end
            end
            default: begin
              if (big || (step >= (W + 1)'(state_i.mag))) begin
                st.mag      = '0;
                st.phase    = pms_pkg::PH_START;
                st.deadline = now + 32'(cfg_i.start_pause_ms);
              end else begin
                st.mag      = state_i.mag - step[W-1:0];
                st.deadline = state_i.deadline + step_ms;
              end
            end
          endcase
        end
      end
      pms_pkg::CMD_RESTART: begin
        st.armed = can_arm;
        st.mag   = '0;
        st.phase = pms_pkg::PH_START;
        if (can_arm) begin
          st.deadline = now + 32'(item_i.extra_delay_ms) + 32'(cfg_i.start_pause_ms);
        end
      end
      pms_pkg::CMD_STOP: begin
        st.armed = 1'b0;
        st.mag   = '0;
        st.phase = pms_pkg::PH_START;
      end
      default: begin
      end
    endcase
  end

  assign state_o   = st;
  assign wait_diff = now - st.deadline;

  always_comb begin
    res_o.scroll_offset  = -$signed({1'b0, st.mag});
    res_o.offset_changed = (item_i.command == pms_pkg::CMD_TIME) && (st.mag != state_i.mag);
    res_o.running        = st.armed;
    if (!st.armed) begin
      res_o.wait_ms = '1;
    end else if (!wait_diff[31]) begin
      res_o.wait_ms = '0;
    end else begin
      res_o.wait_ms = '0 - wait_diff;
    end
  end

endmodule

FILE: hdl/pingpong_marquee_scroller_core.sv
`timescale 1ns / 1ps

// ping-pong marquee scroller for text wider than its viewport
// input channel: in_valid_i / in_stall_o carry an item with a command
//   (time update, restart, stop), the millisecond time and a restart delay
// output channel: out_valid_o / out_stall_i carry one result per item with
//   the offset, a changed flag, the running flag and the time to the next deadline
// config channel: cfg_valid_i / cfg_ready_o write register cfg_index_i with
//   cfg_data_i; ready is always high; the user must make writes while no item
//   is in flight, the block itself does not enforce it
// throughput: one item per cycle while out_stall_i is low; the state update
//   between the input and result registers feeds the next item directly
// stall: while the result register holds an untaken result and out_stall_i is
//   high, the input register holds its item and in_stall_o rises once it is full
// reset: registers return to their reset values (start pause 800 ms, end pause
//   500 ms, widths and enable zero), scrolling is stopped at offset zero and
//   both channels are empty

module pingpong_marquee_scroller_core (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_stall_o,
  input  pms_pkg::in_t                         in_data_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output pms_pkg::out_t                        out_data_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [pms_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [pms_pkg::CFG_DATA_W-1:0]       cfg_data_i
);

  localparam int unsigned W = pms_pkg::WIDTH_BITS;

  pms_pkg::cfg_t   cfg_q;
  pms_pkg::state_t st_q;
  pms_pkg::state_t st_d;
  pms_pkg::in_t    in_q;
  pms_pkg::out_t   out_q;
  pms_pkg::out_t   res_d;
  logic            in_vld_q;
  logic            out_vld_q;
  logic            adv;
  logic            in_accept;
  logic            cfg_we;

  assign adv         = ~out_vld_q | ~out_stall_i;
  assign in_stall_o  = in_vld_q & ~adv;
  assign in_accept   = in_valid_i & ~in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i & cfg_ready_o;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.text_width     <= '0;
      cfg_q.viewport_width <= '0;
      cfg_q.scroll_enable  <= 1'b0;
      cfg_q.start_pause_ms <= pms_pkg::START_PAUSE_RST;
      cfg_q.end_pause_ms   <= pms_pkg::END_PAUSE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        pms_pkg::REG_TEXT_WIDTH:  cfg_q.text_width     <= cfg_data_i[W-1:0];
        pms_pkg::REG_VIEW_WIDTH:  cfg_q.viewport_width <= cfg_data_i[W-1:0];
        pms_pkg::REG_SCROLL_EN:   cfg_q.scroll_enable  <= cfg_data_i[0];
        pms_pkg::REG_START_PAUSE: cfg_q.start_pause_ms <= cfg_data_i[15:0];
        pms_pkg::REG_END_PAUSE:   cfg_q.end_pause_ms   <= cfg_data_i[15:0];
        default: begin
        end
      endcase
    end
  end

  pms_update u_update (
    .item_i  (in_q),
    .cfg_i   (cfg_q),
    .state_i (st_q),
    .state_o (st_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      st_q      <= '0;
    end else begin
      if (in_accept) begin
        in_vld_q <= 1'b1;
      end else if (adv) begin
        in_vld_q <= 1'b0;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
        if (in_vld_q) begin
          st_q <= st_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
    if (adv && in_vld_q) begin
      out_q <= res_d;
    end
  end

  // idle scroller sits at offset zero in the start pause
  a_idle_home: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !st_q.armed |-> (st_q.mag == '0) && (st_q.phase == pms_pkg::PH_START))
    else $error("stopped scroller away from home");

  // a held item moves to the result register once the output side frees
  a_item_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && adv |=> out_vld_q)
    else $error("item lost between stages");

  // input side only stalls with a full input register
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_vld_q && out_vld_q && out_stall_i)
    else $error("input stalled without reason");

  // a moved offset only comes from a running scroller
  a_changed_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.offset_changed |-> out_q.running)
    else $error("offset moved while not running");

  // state holds while the output side is stalled
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(st_q))
    else $error("state changed during stall");

endmodule

FILE: test/tb_pingpong_marquee_scroller_core.sv
`timescale 1ns / 1ps

module tb_pingpong_marquee_scroller_core;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int DIR_ROWS = 22;
  localparam int DIR_ARM_ROW = 5;
  localparam int PHASE_ITEMS = 350;
  localparam int HOLD_CYCLES = 80;
  localparam int IDX_W = pms_pkg::CFG_IDX_W;
  localparam int DATA_W = pms_pkg::CFG_DATA_W;

  localparam pms_pkg::out_t IDLE_RES = '{13'sd0, 1'b0, 1'b0, 32'hFFFF_FFFF};

  typedef struct packed {
    pms_pkg::in_t  item;
    logic          typed;
    pms_pkg::out_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  pms_pkg::in_t in_data;
  logic out_valid;
  logic out_stall = 1'b0;
  pms_pkg::out_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [IDX_W-1:0] cfg_index;
  logic [DATA_W-1:0] cfg_data;

  // scroller prediction state and register copies
  logic pr_armed;
  logic [1:0] pr_phase;
  int pr_offset;
  logic [31:0] pr_deadline;
  logic [pms_pkg::WIDTH_BITS-1:0] cf_text_w;
  logic [pms_pkg::WIDTH_BITS-1:0] cf_view_w;
  logic cf_enable;
  logic [15:0] cf_start_pause;
  logic [15:0] cf_end_pause;

  pms_pkg::out_t pending_results[$];
  dir_row_t dir_tab [DIR_ROWS];
  int errors = 0;
  int items_sent = 0;
  int tx_idle = 0;
  int rx_idle = 0;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  logic [31:0] now_ms;

  pingpong_marquee_scroller_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic bit deadline_reached(logic [31:0] now, logic [31:0] when);
    logic [31:0] diff;
    diff = now - when;
    return diff[31] == 1'b0;
  endfunction

  function automatic pms_pkg::out_t predict_scroll(pms_pkg::in_t it);
    pms_pkg::out_t res;
    int prev_offset;
    logic [31:0] overdue;
    longint step;
    longint moved;
    longint limit;
    logic changed;
    changed = 1'b0;
    case (it.command)
      pms_pkg::CMD_TIME: begin
        if (pr_armed && deadline_reached(it.current_time, pr_deadline)) begin
          prev_offset = pr_offset;
          overdue = it.current_time - pr_deadline;
          step = longint'({32'd0, overdue} / 64'd50) + 1;
          case (pr_phase)
            pms_pkg::PH_START: begin
              pr_phase = pms_pkg::PH_TO_END;
              pr_deadline = it.current_time + pms_pkg::PIXEL_MS;
            end
            pms_pkg::PH_END_PAUSE: begin
              pr_phase = pms_pkg::PH_TO_START;
              pr_deadline = it.current_time + pms_pkg::PIXEL_MS;
            end
            pms_pkg::PH_TO_END: begin
              limit = longint'(cf_text_w) - longint'(cf_view_w);
              if (limit < 0) limit = 0;
              moved = longint'(pr_offset) - step;
              if (-moved >= limit) begin
                pr_offset = int'(-limit);
                pr_phase = pms_pkg::PH_END_PAUSE;
                pr_deadline = it.current_time + 32'(cf_end_pause);
              end else begin
                pr_offset = int'(moved);
                pr_deadline = pr_deadline + 32'(step * 64'd50);
              end
            end
            default: begin
              moved = longint'(pr_offset) + step;
              if (moved >= 0) begin
                pr_offset = 0;
                pr_phase = pms_pkg::PH_START;
                pr_deadline = it.current_time + 32'(cf_start_pause);
              end else begin
                pr_offset = int'(moved);
                pr_deadline = pr_deadline + 32'(step * 64'd50);
              end
            end
          endcase
          changed = (pr_offset != prev_offset);
        end
      end
      pms_pkg::CMD_RESTART: begin
        pr_armed = 1'b0;
        pr_offset = 0;
        pr_phase = pms_pkg::PH_START;
        if (cf_enable && cf_view_w != '0 && cf_text_w > cf_view_w) begin
          pr_armed = 1'b1;
          pr_deadline = it.current_time + 32'(it.extra_delay_ms) + 32'(cf_start_pause);
        end
      end
      pms_pkg::CMD_STOP: begin
        pr_armed = 1'b0;
        pr_offset = 0;
        pr_phase = pms_pkg::PH_START;
      end
      default: ;
    endcase
    res.scroll_offset = pr_offset[pms_pkg::WIDTH_BITS:0];
    res.offset_changed = changed;
    res.running = pr_armed;
    if (!pr_armed) res.wait_ms = 32'hFFFF_FFFF;
    else if (deadline_reached(it.current_time, pr_deadline)) res.wait_ms = '0;
    else res.wait_ms = pr_deadline - it.current_time;
    return res;
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, name, want, got);
      errors++;
    end
  endfunction

  task automatic send_item(pms_pkg::in_t it, bit typed = 1'b0,
                           pms_pkg::out_t typed_res = '0);
    pms_pkg::out_t pred;
    while ($urandom_range(99) < tx_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    pred = predict_scroll(it);
    pending_results.push_back(typed ? typed_res : pred);
    items_sent++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [IDX_W-1:0] idx, logic [DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      pms_pkg::REG_TEXT_WIDTH:  cf_text_w = val[pms_pkg::WIDTH_BITS-1:0];
      pms_pkg::REG_VIEW_WIDTH:  cf_view_w = val[pms_pkg::WIDTH_BITS-1:0];
      pms_pkg::REG_SCROLL_EN:   cf_enable = val[0];
      pms_pkg::REG_START_PAUSE: cf_start_pause = val;
      pms_pkg::REG_END_PAUSE:   cf_end_pause = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_setup(int mode, bit all);
    logic [pms_pkg::WIDTH_BITS-1:0] tw;
    logic [pms_pkg::WIDTH_BITS-1:0] vw;
    logic [15:0] sp;
    logic [15:0] ep;
    logic en;
    wait_results_done();
    sp = 16'($urandom_range(0, 200));
    ep = 16'($urandom_range(0, 200));
    case (mode)
      0: begin
        tw = '1;
        vw = 12'd1;
        sp = '1;
        ep = '1;
      end
      1: begin
        tw = 12'($urandom);
        vw = 12'($urandom);
        sp = 16'($urandom);
        ep = 16'($urandom);
      end
      2: begin
        tw = 12'($urandom);
        vw = '0;
      end
      3: begin
        vw = 12'($urandom_range(1, 4095));
        tw = 12'($urandom_range(0, vw));
      end
      4: begin
        vw = 12'($urandom_range(1, 60));
        tw = vw + 12'($urandom_range(1, 12));
        sp = '0;
        ep = '0;
      end
      default: begin
        vw = 12'($urandom_range(1, 80));
        tw = vw + 12'($urandom_range(1, 12));
      end
    endcase
    en = ($urandom_range(9) != 0);
    if (all || $urandom_range(3) != 0)
      write_reg(pms_pkg::REG_TEXT_WIDTH, {4'($urandom), tw});
    if (all || $urandom_range(3) != 0)
      write_reg(pms_pkg::REG_VIEW_WIDTH, {4'($urandom), vw});
    if (all || $urandom_range(3) != 0)
      write_reg(pms_pkg::REG_SCROLL_EN, {15'($urandom), en});
    if (all || $urandom_range(3) != 0) write_reg(pms_pkg::REG_START_PAUSE, sp);
    if (all || $urandom_range(3) != 0) write_reg(pms_pkg::REG_END_PAUSE, ep);
    if ($urandom_range(7) == 0)
      write_reg(IDX_W'($urandom_range(5, 7)), DATA_W'($urandom));
  endtask

  task automatic run_sequence();
    pms_pkg::in_t it;
    int n;
    int r;
    if ($urandom_range(99) < 80) begin
      if ($urandom_range(9) == 0) now_ms = 32'hFFFF_F000 + 32'($urandom_range(0, 4000));
      else if ($urandom_range(9) == 0) now_ms = $urandom;
      if ($urandom_range(9) < 7) begin
        it.command = pms_pkg::CMD_RESTART;
        it.current_time = now_ms;
        it.extra_delay_ms = ($urandom_range(3) == 0) ? 16'($urandom)
                                                      : 16'($urandom_range(0, 100));
        send_item(it);
      end
      n = $urandom_range(10, 40);
      repeat (n) begin
        r = $urandom_range(99);
        it.command = pms_pkg::CMD_TIME;
        it.extra_delay_ms = 16'($urandom);
        if (r < 75) now_ms += 32'($urandom_range(0, 70));
        else if (r < 86) now_ms += 32'($urandom_range(0, 3000));
        else if (r < 90) now_ms += $urandom;
        else if (r < 95) now_ms -= 32'($urandom_range(0, 100));
        else if (r < 97) it.command = CMD_UNUSED;
        else if (r < 98) it.command = pms_pkg::CMD_STOP;
        else it.command = pms_pkg::CMD_RESTART;
        it.current_time = now_ms;
        send_item(it);
      end
    end else begin
      n = $urandom_range(1, 8);
      repeat (n) begin
        it.command = 2'($urandom);
        it.current_time = $urandom;
        it.extra_delay_ms = 16'($urandom);
        send_item(it);
      end
    end
  endtask

  // receiver stalls, with a long hold-off on request
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen = hold_reqs;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle);
    end
  end

  always @(posedge clk) begin
    pms_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result expected none got %h", $time, out_data);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("scroll_offset", $signed(want.scroll_offset),
                    $signed(out_data.scroll_offset));
        check_field("offset_changed", want.offset_changed, out_data.offset_changed);
        check_field("running", want.running, out_data.running);
        check_field("wait_ms", want.wait_ms, out_data.wait_ms);
      end
    end
  end

  initial begin
    #5000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    pr_armed = 1'b0;
    pr_phase = pms_pkg::PH_START;
    pr_offset = 0;
    pr_deadline = '0;
    cf_text_w = '0;
    cf_view_w = '0;
    cf_enable = 1'b0;
    cf_start_pause = pms_pkg::START_PAUSE_RST;
    cf_end_pause = pms_pkg::END_PAUSE_RST;
    now_ms = $urandom;

    dir_tab = '{
      '{'{pms_pkg::CMD_TIME,    32'd0,         16'd0},    1'b1, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'hFFFF_FFFF, 16'hFFFF}, 1'b1, IDLE_RES},
      '{'{pms_pkg::CMD_RESTART, 32'd100,       16'hFFFF}, 1'b1, IDLE_RES},
      '{'{pms_pkg::CMD_STOP,    32'hFFFF_FFFF, 16'd0},    1'b1, IDLE_RES},
      '{'{CMD_UNUSED,           32'hFFFF_FFFF, 16'hFFFF}, 1'b1, IDLE_RES},
      '{'{pms_pkg::CMD_RESTART, 32'd1000,      16'd0},    1'b1,
        '{13'sd0, 1'b0, 1'b1, 32'd800}},
      '{'{pms_pkg::CMD_TIME,    32'd1500,      16'hFFFF}, 1'b1,
        '{13'sd0, 1'b0, 1'b1, 32'd300}},
      '{'{pms_pkg::CMD_TIME,    32'd1800,      16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'd1850,      16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'd2000,      16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'd1990,      16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'd100000,    16'd0},    1'b0, IDLE_RES},
      '{'{CMD_UNUSED,           32'd100200,    16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'd100500,    16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'd100550,    16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'h7FFF_0000, 16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_STOP,    32'd0,         16'd0},    1'b1, IDLE_RES},
      '{'{pms_pkg::CMD_RESTART, 32'hFFFF_FF00, 16'hFFFF}, 1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'h0001_0220, 16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_RESTART, 32'd0,         16'd0},    1'b1,
        '{13'sd0, 1'b0, 1'b1, 32'd800}},
      '{'{pms_pkg::CMD_TIME,    32'h8000_0320, 16'd0},    1'b0, IDLE_RES},
      '{'{pms_pkg::CMD_TIME,    32'h8000_031F, 16'd0},    1'b0, IDLE_RES}
    };

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (i == DIR_ARM_ROW) begin
        wait_results_done();
        write_reg(pms_pkg::REG_TEXT_WIDTH, 16'd20);
        write_reg(pms_pkg::REG_VIEW_WIDTH, 16'd10);
        write_reg(pms_pkg::REG_SCROLL_EN, 16'd1);
      end
      send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].res);
    end

    for (int p = 0; p < 3; p++) begin
      int goal;
      wait_results_done();
      case (p)
        0: begin
          tx_idle = 14;
          rx_idle <= 88;
        end
        1: begin
          tx_idle = 88;
          rx_idle <= 14;
        end
        default: begin
          tx_idle = 0;
          rx_idle <= 0;
        end
      endcase
      random_setup(p == 0 ? 0 : (p == 1 ? 1 : 4), 1'b1);
      if (p == 2) begin
        hold_reqs <= hold_reqs + 1;
        repeat (3) run_sequence();
      end
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) begin
        if ($urandom_range(1) == 0) random_setup($urandom_range(9), 1'b0);
        run_sequence();
      end
    end

    wait_results_done();
    repeat (10) @(posedge clk);
    if (errors == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
